@@ hw/rtl/fpfl_pkg.sv @@
// Shared types and constants for the fixed pool free-list allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package fpfl_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ALLOC   = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FREED   = 3'd2,
        ST_IGNORED = 3'd3,
        ST_OUTSIDE = 3'd4
    } t_status;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request and launch the memory reads
        logic commit;  // update the free list and load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;  // result register full and stalled downstream
    } t_ctrl_sts;

endpackage

@@ hw/rtl/fpfl_ctrl.sv @@
// Controller state machine of the fixed pool free-list allocator.
// Depends on fpfl_pkg for the state type and the command and status structs.
module fpfl_ctrl
    import fpfl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output t_ctrl_cmd o_cmd,
    input  t_ctrl_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.commit = !i_sts.out_blocked;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/fpfl_datapath.sv @@
// Datapath of the fixed pool free-list allocator: link and in-use memories,
// list head, fill counter, request registers and the result register. Uses fpfl_pkg.
module fpfl_datapath
    import fpfl_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_ctrl_sts           o_sts,
    input  logic                i_in_mode,
    input  logic [SLOT_W-1:0]   i_in_slot,
    input  logic                i_in_outside,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SLOT_W-1:0]   o_out_granted_slot,
    output logic [STATUS_W-1:0] o_out_status
);

    localparam int IW = $clog2(POOL_SIZE);      // slot index width
    localparam int LW = $clog2(POOL_SIZE + 1);  // link width, includes null

    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SIZE);

    // Memories; entries at or above the fill count were never written and
    // read as their reset values instead.
    logic [LW-1:0] link_mem [POOL_SIZE];
    logic          use_mem  [POOL_SIZE];

    logic [LW-1:0]       r_head;
    logic [LW-1:0]       r_fill;
    logic                r_mode;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_outside;
    logic [LW-1:0]       r_link_rd;
    logic                r_use_rd;
    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_out_granted;
    logic [STATUS_W-1:0] r_out_status;

    logic          in_slot_ok;
    logic [IW-1:0] rd_link_addr;
    logic [IW-1:0] rd_use_addr;
    logic          head_valid;
    logic [IW-1:0] got_idx;
    logic          head_fresh;
    logic [LW-1:0] next_head;
    logic          slot_ok;
    logic [IW-1:0] slot_idx;
    logic          slot_in_use;
    logic          do_alloc;
    logic          do_free;
    t_status       res_status;
    logic [SLOT_W-1:0] res_granted;

    // Read addresses at request capture.
    assign in_slot_ok   = 32'(i_in_slot) < POOL_SIZE;
    assign rd_use_addr  = in_slot_ok ? IW'(i_in_slot) : '0;
    assign rd_link_addr = (r_head < LINK_NULL) ? IW'(r_head) : '0;

    // Execute-cycle decode.
    assign head_valid  = r_head < LINK_NULL;
    assign got_idx     = IW'(r_head);
    assign head_fresh  = r_head >= r_fill;
    assign next_head   = head_fresh ? LW'(r_head + LW'(1)) : r_link_rd;
    assign slot_ok     = 32'(r_slot) < POOL_SIZE;
    assign slot_idx    = IW'(r_slot);
    assign slot_in_use = (LW'(r_slot) < r_fill) && r_use_rd;

    assign do_alloc = i_cmd.commit && (r_mode == MODE_ALLOC) && head_valid;
    assign do_free  = i_cmd.commit && (r_mode == MODE_FREE) && !r_outside
                      && slot_ok && slot_in_use;

    always_comb begin
        res_granted = '0;
        if (r_mode == MODE_ALLOC) begin
            if (head_valid) begin
                res_status  = ST_ALLOC;
                res_granted = SLOT_W'(got_idx);
            end else begin
                res_status = ST_EMPTY;
            end
        end else if (r_outside) begin
            res_status = ST_OUTSIDE;
        end else if (slot_ok && slot_in_use) begin
            res_status = ST_FREED;
        end else begin
            res_status = ST_IGNORED;
        end
    end

    // Link memory: one read, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (do_free) begin
            link_mem[slot_idx] <= r_head;
        end
        if (i_cmd.load) begin
            r_link_rd <= link_mem[rd_link_addr];
        end
    end

    // In-use memory: one read, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (do_alloc) begin
            use_mem[got_idx] <= 1'b1;
        end else if (do_free) begin
            use_mem[slot_idx] <= 1'b0;
        end
        if (i_cmd.load) begin
            r_use_rd <= use_mem[rd_use_addr];
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_in_mode;
            r_slot    <= i_in_slot;
            r_outside <= i_in_outside;
        end
    end

    // Free-list control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (do_alloc) begin
            r_head <= next_head;
            if (head_fresh) begin
                r_fill <= LW'(r_fill + LW'(1));
            end
        end else if (do_free) begin
            r_head <= LW'(r_slot);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_granted <= res_granted;
            r_out_status  <= res_status;
        end
    end

    assign o_sts.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_granted_slot = r_out_granted;
    assign o_out_status       = r_out_status;

endmodule

@@ hw/rtl/fixed_pool_free_list_allocator.sv @@
// Fixed pool free-list allocator: the accepting edge captures a request and launches
// the registered read of the link and in-use memories; the list update and result
// register load follow, held while an earlier result is stalled. No new request is
// taken until the current one has committed. Reset is synchronous and active low; it
// clears the controller state, the head, the fill count and the result valid. No
// clearing pass runs: slots at or above the fill count read as their reset chain.
module fixed_pool_free_list_allocator
    import fpfl_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Request channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_in_mode,
    input  logic [SLOT_W-1:0]   i_in_slot,
    input  logic                i_in_outside,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SLOT_W-1:0]   o_out_granted_slot,
    output logic [STATUS_W-1:0] o_out_status
);

    // The controller takes a request in its idle state, which captures the
    // request and launches the memory reads. In the following cycle it commits
    // the list update and loads the result register, waiting there only while
    // an earlier result is still stalled at the output. A request is accepted
    // even while a finished result waits to be taken.
    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    fpfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // The datapath holds the link memory, the in-use memory, the list head,
    // and a fill count that marks the lowest slot never allocated since reset.
    fpfl_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_in_mode          (i_in_mode),
        .i_in_slot          (i_in_slot),
        .i_in_outside       (i_in_outside),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_granted_slot (o_out_granted_slot),
        .o_out_status       (o_out_status)
    );

endmodule
